// ===== design/udl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, character constants and hex helpers for the URL percent decoder.
// No dependencies.
package udl_pkg;

    localparam logic [7:0]  CH_PCT   = 8'h25;
    localparam logic [7:0]  CH_PLUS  = 8'h2b;
    localparam logic [7:0]  CH_SPACE = 8'h20;
    localparam logic [15:0] LIMIT_RST = 16'd255;
    localparam int          CAND_N   = 3;
    localparam int          GRP_N    = 4;

    typedef enum logic [2:0] {
        HOLD_NONE = 3'b001,
        HOLD_PCT  = 3'b010,
        HOLD_DIG  = 3'b100
    } t_hold;

    typedef struct packed {
        logic [CAND_N-1:0][7:0] cand;
        logic [1:0]             nc;
        t_hold                  hold;
        logic [7:0]             held;
    } t_dec;

    typedef struct packed {
        logic [GRP_N-1:0][7:0] bytes;
        logic [2:0]            n;
        logic                  term;
        logic [16:0]           cnt;
    } t_grp;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end else begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

endpackage

// ===== design/udl_decode.sv =====
`timescale 1ns / 1ps
// Escape decoder: from the held state and one input word, lists the bytes due
// (before limit check) and the next held state. Depends on udl_pkg.
module udl_decode import udl_pkg::*; (
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  t_hold      i_hold,
    input  logic [7:0] i_held,
    output t_dec       o_dec
);

    always_comb begin
        logic [CAND_N-1:0][7:0] cand;
        logic [1:0]             n;
        t_hold                  hold;
        logic [7:0]             held;
        logic                   do_fresh;

        cand     = '0;
        n        = 2'd0;
        hold     = HOLD_NONE;
        held     = i_held;
        do_fresh = 1'b0;

        case (i_hold)
            HOLD_PCT: begin
                if (is_hex(i_byte)) begin
                    held = i_byte;
                    hold = HOLD_DIG;
                end else begin
                    cand[n]  = CH_PCT;
                    n        = n + 2'd1;
                    do_fresh = 1'b1;
                end
            end
            HOLD_DIG: begin
                if (is_hex(i_byte)) begin
                    cand[n] = {hex_val(i_held), hex_val(i_byte)};
                    n       = n + 2'd1;
                end else begin
                    cand[n]  = CH_PCT;
                    n        = n + 2'd1;
                    cand[n]  = i_held;
                    n        = n + 2'd1;
                    do_fresh = 1'b1;
                end
            end
            default: begin
                do_fresh = 1'b1;
            end
        endcase

        if (do_fresh) begin
            if (i_byte == CH_PCT) begin
                hold = HOLD_PCT;
            end else begin
                cand[n] = (i_byte == CH_PLUS) ? CH_SPACE : i_byte;
                n       = n + 2'd1;
            end
        end

        // flush an unfinished escape at end of string
        if (i_last) begin
            if (hold == HOLD_PCT) begin
                cand[n] = CH_PCT;
                n       = n + 2'd1;
            end else if (hold == HOLD_DIG) begin
                cand[n] = CH_PCT;
                n       = n + 2'd1;
                cand[n] = held;
                n       = n + 2'd1;
            end
        end

        o_dec.cand = cand;
        o_dec.nc   = n;
        o_dec.hold = hold;
        o_dec.held = held;
    end

endmodule

// ===== design/udl_outq.sv =====
`timescale 1ns / 1ps
// Result buffer: loads the group of results of one word and shifts them out one
// per cycle on the output handshake. Depends on udl_pkg.
module udl_outq import udl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_grp        i_grp,
    output logic        o_load_ok,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_is_terminator,
    output logic [16:0] o_out_count,
    output logic        o_last
);

    logic [GRP_N-1:0][7:0] r_bytes, n_bytes;
    logic [2:0]            r_rem, n_rem;
    logic                  r_term, n_term;
    logic [16:0]           r_cnt, n_cnt;
    logic                  take;

    assign o_out_valid     = (r_rem != 3'd0);
    assign take            = o_out_valid && i_out_ready;
    assign o_load_ok       = (r_rem == 3'd0) || (r_rem == 3'd1 && i_out_ready);
    assign o_last          = (r_rem == 3'd1);
    assign o_is_terminator = o_last && r_term;
    assign o_out_byte      = r_bytes[0];
    assign o_out_count     = o_is_terminator ? r_cnt : 17'd0;

    always_comb begin
        n_rem   = r_rem;
        n_bytes = r_bytes;
        n_term  = r_term;
        n_cnt   = r_cnt;
        if (i_load) begin
            n_rem   = i_grp.n;
            n_bytes = i_grp.bytes;
            n_term  = i_grp.term;
            n_cnt   = i_grp.cnt;
        end else if (take) begin
            n_rem   = r_rem - 3'd1;
            n_bytes = {8'h00, r_bytes[GRP_N-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= 3'd0;
        end else begin
            r_rem <= n_rem;
        end
        r_bytes <= n_bytes;
        r_term  <= n_term;
        r_cnt   <= n_cnt;
    end

endmodule

// ===== design/url_percent_decoder_limited_unit.sv =====
`timescale 1ns / 1ps
// URL percent decoder with output limit. A word goes through the input register,
// then the result buffer, before its first result. Throughput: 1 word per cycle
// while the output is ready and each word gives at most one result; a word with
// more results holds the input until the one-result-per-cycle buffer drains it.
// Reset: synchronous active-low i_rst_n clears state; limit returns to 255.
module url_percent_decoder_limited_unit import udl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_is_terminator,
    output logic [16:0] o_out_count,
    output logic        o_last
);

    logic        r_in_valid, n_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic [15:0] r_limit;
    t_hold       r_hold, n_hold;
    logic [7:0]  r_held, n_held;
    logic [16:0] r_cnt, n_cnt;
    logic        r_stopped, n_stopped;

    t_dec        dec;
    t_grp        grp;
    logic        load_ok;
    logic        move;
    logic [1:0]  nc;
    logic [16:0] room;
    logic [1:0]  avail;
    logic [1:0]  k;

    udl_decode u_dec (
        .i_byte (r_in_byte),
        .i_last (r_in_last),
        .i_hold (r_hold),
        .i_held (r_held),
        .o_dec  (dec)
    );

    assign move       = r_in_valid && load_ok;
    assign o_in_ready = !r_in_valid || load_ok;
    assign n_in_valid = i_in_valid ? 1'b1 : (r_in_valid && !move);

    // limit check over the due bytes, in order
    always_comb begin
        nc    = r_stopped ? 2'd0 : dec.nc;
        room  = (r_cnt >= {1'b0, r_limit}) ? 17'd0 : ({1'b0, r_limit} - r_cnt);
        avail = (room >= 17'd3) ? 2'd3 : room[1:0];
        k     = (nc < avail) ? nc : avail;

        for (int i = 0; i < GRP_N; i++) begin
            grp.bytes[i] = (i < CAND_N && 2'(i) < k) ? dec.cand[i % CAND_N] : 8'h00;
        end
        grp.n    = {1'b0, k} + {2'b00, r_in_last};
        grp.term = r_in_last;
        grp.cnt  = r_cnt + {15'd0, k} + 17'd1;

        n_hold    = r_hold;
        n_held    = r_held;
        n_cnt     = r_cnt;
        n_stopped = r_stopped;
        if (move) begin
            if (r_in_last) begin
                n_hold    = HOLD_NONE;
                n_held    = 8'h00;
                n_cnt     = 17'd0;
                n_stopped = 1'b0;
            end else begin
                n_hold    = r_stopped ? r_hold : dec.hold;
                n_held    = r_stopped ? r_held : dec.held;
                n_cnt     = r_cnt + {15'd0, k};
                n_stopped = r_stopped || (nc > avail);
            end
        end
    end

    udl_outq u_outq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (move),
        .i_grp           (grp),
        .o_load_ok       (load_ok),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_is_terminator (o_is_terminator),
        .o_out_count     (o_out_count),
        .o_last          (o_last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_limit    <= LIMIT_RST;
            r_hold     <= HOLD_NONE;
            r_held     <= 8'h00;
            r_cnt      <= 17'd0;
            r_stopped  <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            r_hold    <= n_hold;
            r_held    <= n_held;
            r_cnt     <= n_cnt;
            r_stopped <= n_stopped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

endmodule

// ===== design/udl_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the URL percent decoder, bound to the top level.
// Depends on url_percent_decoder_limited_unit.
module udl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_out_byte,
    input logic        o_is_terminator,
    input logic [16:0] o_out_count,
    input logic        o_last
);

    a_count_only_on_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_terminator |-> o_out_count == 17'd0)
        else $error("count shown on a non-terminator word");

    a_term_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_terminator |-> o_last && o_out_byte == 8'h00 &&
        o_out_count != 17'd0)
        else $error("malformed terminator word");

    a_term_closes_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last && i_out_ready |=> o_out_valid)
        else $error("result group broken off");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte) &&
        $stable(o_last))
        else $error("stalled output word changed");

endmodule

bind url_percent_decoder_limited_unit udl_checker u_udl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_out_byte      (o_out_byte),
    .o_is_terminator (o_is_terminator),
    .o_out_count     (o_out_count),
    .o_last          (o_last)
);
